### design/assert_macros.svh
// Assertion helpers shared by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define TLTE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlte check failed");

// Next-cycle implication, masked during reset.
`define TLTE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlte check failed");

`endif

### design/tlte_pkg.sv
`default_nettype none
package tlte_pkg;

  localparam int CW    = 24;                 // coordinate width
  localparam int AW    = CW + 1;             // |end - begin|
  localparam int PW    = $clog2(AW);         // msb position
  localparam int NW    = 31;                 // normalized magnitude
  localparam int SQW   = 2 * NW;             // one square
  localparam int RW    = 32;                 // root, divisor, quotient
  localparam int RMW   = RW + 4;             // root remainder
  localparam int DRW   = RW + 1;             // divide remainder
  localparam int TW    = 16;                 // thickness
  localparam int PRW   = TW + RW;            // thickness * unit
  localparam int FW    = 17;                 // offset magnitude
  localparam int OW    = FW + 1;             // signed offset
  localparam int VW    = ((CW > OW) ? CW : OW) + 2;
  localparam int ITER  = RW / 2;             // two result bits per cycle
  localparam int CNTW  = $clog2(ITER + 1);
  localparam int KW    = 5;
  localparam int IN_TW  = ((4 * CW + 7) / 8) * 8;
  localparam int OUT_TW = ((2 * CW + KW + 7) / 8) * 8;

  localparam logic [KW-1:0] VERTEX_LAST = KW'(17);
  localparam logic [TW-1:0] THICK_RESET = TW'(256);

  localparam logic [1:0] PERP_NEG_FULL = 2'd0;
  localparam logic [1:0] PERP_POS_FULL = 2'd1;
  localparam logic [1:0] PERP_NEG_HALF = 2'd2;
  localparam logic [1:0] PERP_POS_HALF = 2'd3;

  localparam logic [1:0] CAP_NONE = 2'd0;
  localparam logic [1:0] CAP_POS  = 2'd1;
  localparam logic [1:0] CAP_NEG  = 2'd2;

  typedef struct packed {
    logic       at_end;
    logic [1:0] perp;
    logic [1:0] cap;
  } recipe_t;

  typedef struct packed {
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic                 sx_neg;
    logic                 sy_neg;
    logic                 degen;
  } side_t;

  typedef struct packed {
    logic signed [OW-1:0] px;
    logic signed [OW-1:0] py;
    logic signed [OW-1:0] hx;
    logic signed [OW-1:0] hy;
    logic signed [OW-1:0] cx;
    logic signed [OW-1:0] cy;
  } offs_t;

  // Quad, cap at the end, cap at the begin.
  function automatic recipe_t vertex_recipe(input logic [KW-1:0] k);
    recipe_t r;
    case (k)
      5'd0:  r = '{1'b0, PERP_NEG_FULL, CAP_NONE};
      5'd1:  r = '{1'b1, PERP_NEG_FULL, CAP_NONE};
      5'd2:  r = '{1'b1, PERP_POS_FULL, CAP_NONE};
      5'd3:  r = '{1'b1, PERP_POS_FULL, CAP_NONE};
      5'd4:  r = '{1'b0, PERP_POS_FULL, CAP_NONE};
      5'd5:  r = '{1'b0, PERP_NEG_FULL, CAP_NONE};
      5'd6:  r = '{1'b1, PERP_NEG_FULL, CAP_NONE};
      5'd7:  r = '{1'b1, PERP_NEG_HALF, CAP_POS};
      5'd8:  r = '{1'b1, PERP_POS_HALF, CAP_POS};
      5'd9:  r = '{1'b1, PERP_POS_HALF, CAP_POS};
      5'd10: r = '{1'b1, PERP_POS_FULL, CAP_NONE};
      5'd11: r = '{1'b1, PERP_NEG_FULL, CAP_NONE};
      5'd12: r = '{1'b0, PERP_NEG_HALF, CAP_NEG};
      5'd13: r = '{1'b0, PERP_NEG_FULL, CAP_NONE};
      5'd14: r = '{1'b0, PERP_POS_FULL, CAP_NONE};
      5'd15: r = '{1'b0, PERP_POS_FULL, CAP_NONE};
      5'd16: r = '{1'b0, PERP_POS_HALF, CAP_NEG};
      5'd17: r = '{1'b0, PERP_NEG_HALF, CAP_NEG};
      default: r = '{1'b0, PERP_NEG_FULL, CAP_NONE};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### design/thick_line_triangle_expander_core.sv
// Channel | Dir | Word
// in_     | in  | tdata: begin_x, begin_y, end_x, end_y (low bits first)
// out_    | out | tdata: vertex_x, vertex_y, vertex_number; tuser: degenerate;
//         |     | tlast: last_vertex
// cfg_    | in  | data: thickness (always ready)
// A segment gives 18 output words, vertex numbers 0 to 17; the vertex
// emitter takes the next segment only as its last vertex goes out.
// From the input word, the first vertex passes five front stages (s1 to s5),
// square root, divider, s6 multiply, s7 rounding, emitter, output register.
// Synchronous active-low reset empties the pipeline and sets thickness 256.
// A stalled output holds its word; every stage holds while downstream is full.
`default_nettype none
module thick_line_triangle_expander_core import tlte_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_tvalid,
  output logic               in_tready,
  input  wire [IN_TW-1:0]    in_tdata,   // begin_x, begin_y, end_x, end_y
  output logic               out_tvalid,
  input  wire                out_tready,
  output logic [OUT_TW-1:0]  out_tdata,  // vertex_x, vertex_y, vertex_number
  output logic               out_tuser,  // degenerate
  output logic               out_tlast,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire [TW-1:0]       cfg_data
);

  localparam logic signed [VW-1:0] SAT_HI = {{(VW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [VW-1:0] SAT_LO = {{(VW-CW+1){1'b1}}, {(CW-1){1'b0}}};
  localparam logic [PRW:0] RND_F = (PRW+1)'(1) << 30;
  localparam logic [PRW:0] RND_G = (PRW+1)'(1) << 31;

  logic [TW-1:0] thick_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thick_r <= THICK_RESET;
    end else if (cfg_valid) begin
      thick_r <= cfg_data;
    end
  end

  // ready chain, back to front
  logic out_free, em_load_ok, s7_rdy, s6_rdy, dv_rdy, sq_rdy;
  logic s5_rdy, s4_rdy, s3_rdy, s2_rdy, s1_rdy;
  logic sq_done, dv_done;

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, sq_v_r, dv_v_r, s6_v_r, s7_v_r;
  logic em_v_r, out_v_r;
  logic [CNTW-1:0] sq_cnt_r, dv_cnt_r;
  logic [KW-1:0] em_k_r;

  assign out_free   = !out_v_r || out_tready;
  assign em_load_ok = !em_v_r || (out_free && em_k_r == VERTEX_LAST);
  assign s7_rdy     = !s7_v_r || em_load_ok;
  assign s6_rdy     = !s6_v_r || s7_rdy;
  assign dv_done    = dv_v_r && dv_cnt_r == '0;
  assign dv_rdy     = !dv_v_r || (dv_done && s6_rdy);
  assign sq_done    = sq_v_r && sq_cnt_r == '0;
  assign sq_rdy     = !sq_v_r || (sq_done && dv_rdy);
  assign s5_rdy     = !s5_v_r || sq_rdy;
  assign s4_rdy     = !s4_v_r || s5_rdy;
  assign s3_rdy     = !s3_v_r || s4_rdy;
  assign s2_rdy     = !s2_v_r || s3_rdy;
  assign s1_rdy     = !s1_v_r || s2_rdy;
  assign in_tready  = s1_rdy;

  // s1: capture the word
  side_t s1_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= in_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (s1_rdy && in_tvalid) begin
      s1_side_r.bx     <= in_tdata[0*CW +: CW];
      s1_side_r.by     <= in_tdata[1*CW +: CW];
      s1_side_r.ex     <= in_tdata[2*CW +: CW];
      s1_side_r.ey     <= in_tdata[3*CW +: CW];
      s1_side_r.sx_neg <= 1'b0;
      s1_side_r.sy_neg <= 1'b0;
      s1_side_r.degen  <= 1'b0;
    end
  end

  // s2: differences and magnitudes
  logic signed [AW-1:0] dx, dy;
  logic [AW-1:0] s2_ax_r, s2_ay_r;
  side_t s2_side_r, s2_side_nxt;
  assign dx = AW'(s1_side_r.ex) - AW'(s1_side_r.bx);
  assign dy = AW'(s1_side_r.ey) - AW'(s1_side_r.by);
  always_comb begin
    s2_side_nxt        = s1_side_r;
    s2_side_nxt.sx_neg = dx[AW-1];
    s2_side_nxt.sy_neg = dy[AW-1];
    s2_side_nxt.degen  = (dx == '0) && (dy == '0);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (s2_rdy && s1_v_r) begin
      s2_side_r <= s2_side_nxt;
      s2_ax_r <= dx[AW-1] ? AW'(-dx) : AW'(dx);
      s2_ay_r <= dy[AW-1] ? AW'(-dy) : AW'(dy);
    end
  end

  // s3: leading one of the larger magnitude
  logic [AW-1:0] mx;
  logic [PW-1:0] pos;
  logic [AW-1:0] s3_ax_r, s3_ay_r;
  logic [PW-1:0] s3_pos_r;
  side_t s3_side_r;
  always_comb begin
    mx  = (s2_ax_r > s2_ay_r) ? s2_ax_r : s2_ay_r;
    pos = '0;
    for (int i = 0; i < AW; i++) begin
      if (mx[i]) pos = PW'(i);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_r <= s2_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (s3_rdy && s2_v_r) begin
      s3_side_r <= s2_side_r;
      s3_ax_r   <= s2_ax_r;
      s3_ay_r   <= s2_ay_r;
      s3_pos_r  <= pos;
    end
  end

  // s4: scale both so the larger has its msb at bit NW-1 (truncate on right shift)
  logic [AW+NW-1:0] wide_x, wide_y;
  logic [PW:0] shamt;
  logic [NW-1:0] s4_nx_r, s4_ny_r;
  side_t s4_side_r;
  assign shamt  = {1'b0, s3_pos_r} + (PW+1)'(1);
  assign wide_x = {s3_ax_r, {NW{1'b0}}} >> shamt;
  assign wide_y = {s3_ay_r, {NW{1'b0}}} >> shamt;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (s4_rdy) begin
      s4_v_r <= s3_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (s4_rdy && s3_v_r) begin
      s4_side_r <= s3_side_r;
      s4_nx_r   <= wide_x[NW-1:0];
      s4_ny_r   <= wide_y[NW-1:0];
    end
  end

  // s5: squares
  logic [SQW-1:0] s5_sqx_r, s5_sqy_r;
  logic [NW-1:0] s5_nx_r, s5_ny_r;
  side_t s5_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (s5_rdy) begin
      s5_v_r <= s4_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (s5_rdy && s4_v_r) begin
      s5_side_r <= s4_side_r;
      s5_nx_r   <= s4_nx_r;
      s5_ny_r   <= s4_ny_r;
      s5_sqx_r  <= s4_nx_r * s4_nx_r;
      s5_sqy_r  <= s4_ny_r * s4_ny_r;
    end
  end

  // square root, two result bits per cycle
  logic [2*RW-1:0] sq_val_r, sq_val_nxt;
  logic [RMW-1:0] sq_rem_r, sq_rem_nxt;
  logic [RW-1:0] sq_root_r, sq_root_nxt;
  logic [NW-1:0] sq_nx_r, sq_ny_r;
  side_t sq_side_r;
  always_comb begin
    logic [RMW-1:0] trial;
    sq_val_nxt  = sq_val_r;
    sq_rem_nxt  = sq_rem_r;
    sq_root_nxt = sq_root_r;
    for (int j = 0; j < 2; j++) begin
      sq_rem_nxt = {sq_rem_nxt[RMW-3:0], sq_val_nxt[2*RW-1 -: 2]};
      sq_val_nxt = {sq_val_nxt[2*RW-3:0], 2'b00};
      trial = {{(RMW-RW-2){1'b0}}, sq_root_nxt, 2'b01};
      if (sq_rem_nxt >= trial) begin
        sq_rem_nxt  = sq_rem_nxt - trial;
        sq_root_nxt = {sq_root_nxt[RW-2:0], 1'b1};
      end else begin
        sq_root_nxt = {sq_root_nxt[RW-2:0], 1'b0};
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r   <= 1'b0;
      sq_cnt_r <= '0;
    end else begin
      if (sq_rdy) sq_v_r <= s5_v_r;
      if (sq_rdy && s5_v_r) begin
        sq_cnt_r <= CNTW'(ITER);
      end else if (sq_cnt_r != '0) begin
        sq_cnt_r <= sq_cnt_r - CNTW'(1);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (sq_rdy && s5_v_r) begin
      sq_side_r <= s5_side_r;
      sq_nx_r   <= s5_nx_r;
      sq_ny_r   <= s5_ny_r;
      sq_val_r  <= (2*RW)'({1'b0, s5_sqx_r} + {1'b0, s5_sqy_r});
      sq_rem_r  <= '0;
      sq_root_r <= '0;
    end else if (sq_cnt_r != '0) begin
      sq_val_r  <= sq_val_nxt;
      sq_rem_r  <= sq_rem_nxt;
      sq_root_r <= sq_root_nxt;
    end
  end

  // two dividers sharing the root as divisor, two quotient bits per cycle
  logic [2*NW-1:0] numx, numy;
  logic [RW-1:0] dv_len_r;
  logic [DRW-1:0] dv_remx_r, dv_remy_r, dv_remx_nxt, dv_remy_nxt;
  logic [RW-1:0] dv_lox_r, dv_loy_r, dv_lox_nxt, dv_loy_nxt;
  logic [RW-1:0] dv_qx_r, dv_qy_r, dv_qx_nxt, dv_qy_nxt;
  side_t dv_side_r;
  assign numx = {sq_nx_r, {(NW-1){1'b0}}} + (2*NW)'(sq_root_r >> 1);
  assign numy = {sq_ny_r, {(NW-1){1'b0}}} + (2*NW)'(sq_root_r >> 1);
  always_comb begin
    logic [DRW:0] r2x, r2y;
    dv_remx_nxt = dv_remx_r;
    dv_remy_nxt = dv_remy_r;
    dv_lox_nxt  = dv_lox_r;
    dv_loy_nxt  = dv_loy_r;
    dv_qx_nxt   = dv_qx_r;
    dv_qy_nxt   = dv_qy_r;
    for (int j = 0; j < 2; j++) begin
      r2x = {dv_remx_nxt, dv_lox_nxt[RW-1]};
      r2y = {dv_remy_nxt, dv_loy_nxt[RW-1]};
      dv_lox_nxt = {dv_lox_nxt[RW-2:0], 1'b0};
      dv_loy_nxt = {dv_loy_nxt[RW-2:0], 1'b0};
      if (r2x >= {2'b00, dv_len_r}) begin
        r2x = r2x - {2'b00, dv_len_r};
        dv_qx_nxt = {dv_qx_nxt[RW-2:0], 1'b1};
      end else begin
        dv_qx_nxt = {dv_qx_nxt[RW-2:0], 1'b0};
      end
      if (r2y >= {2'b00, dv_len_r}) begin
        r2y = r2y - {2'b00, dv_len_r};
        dv_qy_nxt = {dv_qy_nxt[RW-2:0], 1'b1};
      end else begin
        dv_qy_nxt = {dv_qy_nxt[RW-2:0], 1'b0};
      end
      dv_remx_nxt = r2x[DRW-1:0];
      dv_remy_nxt = r2y[DRW-1:0];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r   <= 1'b0;
      dv_cnt_r <= '0;
    end else begin
      if (dv_rdy) dv_v_r <= sq_done;
      if (dv_rdy && sq_done) begin
        dv_cnt_r <= CNTW'(ITER);
      end else if (dv_cnt_r != '0) begin
        dv_cnt_r <= dv_cnt_r - CNTW'(1);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (dv_rdy && sq_done) begin
      dv_side_r <= sq_side_r;
      dv_len_r  <= sq_root_r;
      dv_remx_r <= DRW'(numx[2*NW-1:RW]);
      dv_remy_r <= DRW'(numy[2*NW-1:RW]);
      dv_lox_r  <= numx[RW-1:0];
      dv_loy_r  <= numy[RW-1:0];
      dv_qx_r   <= '0;
      dv_qy_r   <= '0;
    end else if (dv_cnt_r != '0) begin
      dv_remx_r <= dv_remx_nxt;
      dv_remy_r <= dv_remy_nxt;
      dv_lox_r  <= dv_lox_nxt;
      dv_loy_r  <= dv_loy_nxt;
      dv_qx_r   <= dv_qx_nxt;
      dv_qy_r   <= dv_qy_nxt;
    end
  end

  // s6: thickness times unit vector
  logic [PRW-1:0] s6_prx_r, s6_pry_r;
  side_t s6_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (s6_rdy) begin
      s6_v_r <= dv_done;
    end
  end
  always_ff @(posedge clk) begin
    if (s6_rdy && dv_done) begin
      s6_side_r <= dv_side_r;
      s6_prx_r  <= thick_r * dv_qx_r;
      s6_pry_r  <= thick_r * dv_qy_r;
    end
  end

  // s7: round magnitudes, apply signs
  logic [PRW:0] sfx, sfy, sgx, sgy;
  logic signed [OW-1:0] fxs, fys, gxs, gys;
  offs_t offs_nxt, s7_offs_r;
  side_t s7_side_r;
  always_comb begin
    sfx = {1'b0, s6_prx_r} + RND_F;
    sfy = {1'b0, s6_pry_r} + RND_F;
    sgx = {1'b0, s6_prx_r} + RND_G;
    sgy = {1'b0, s6_pry_r} + RND_G;
    fxs = $signed({1'b0, sfx[31 +: FW]});
    fys = $signed({1'b0, sfy[31 +: FW]});
    gxs = $signed({1'b0, sgx[32 +: FW]});
    gys = $signed({1'b0, sgy[32 +: FW]});
    offs_nxt.px = s6_side_r.sy_neg ? fys : -fys;
    offs_nxt.py = s6_side_r.sx_neg ? -fxs : fxs;
    offs_nxt.hx = s6_side_r.sy_neg ? gys : -gys;
    offs_nxt.hy = s6_side_r.sx_neg ? -gxs : gxs;
    offs_nxt.cx = s6_side_r.sx_neg ? -fxs : fxs;
    offs_nxt.cy = s6_side_r.sy_neg ? -fys : fys;
    if (s6_side_r.degen) offs_nxt = '0;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else if (s7_rdy) begin
      s7_v_r <= s6_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (s7_rdy && s6_v_r) begin
      s7_side_r <= s6_side_r;
      s7_offs_r <= offs_nxt;
    end
  end

  // vertex emitter: one vertex per free output slot
  side_t em_side_r;
  offs_t em_offs_r;
  recipe_t rc;
  logic signed [VW-1:0] vx_nxt, vy_nxt, vx_sat, vy_sat;
  always_comb begin
    rc = vertex_recipe(em_k_r);
    vx_nxt = rc.at_end ? VW'(em_side_r.ex) : VW'(em_side_r.bx);
    vy_nxt = rc.at_end ? VW'(em_side_r.ey) : VW'(em_side_r.by);
    case (rc.perp)
      PERP_NEG_FULL: begin
        vx_nxt = vx_nxt - VW'(em_offs_r.px);
        vy_nxt = vy_nxt - VW'(em_offs_r.py);
      end
      PERP_POS_FULL: begin
        vx_nxt = vx_nxt + VW'(em_offs_r.px);
        vy_nxt = vy_nxt + VW'(em_offs_r.py);
      end
      PERP_NEG_HALF: begin
        vx_nxt = vx_nxt - VW'(em_offs_r.hx);
        vy_nxt = vy_nxt - VW'(em_offs_r.hy);
      end
      default: begin
        vx_nxt = vx_nxt + VW'(em_offs_r.hx);
        vy_nxt = vy_nxt + VW'(em_offs_r.hy);
      end
    endcase
    case (rc.cap)
      CAP_POS: begin
        vx_nxt = vx_nxt + VW'(em_offs_r.cx);
        vy_nxt = vy_nxt + VW'(em_offs_r.cy);
      end
      CAP_NEG: begin
        vx_nxt = vx_nxt - VW'(em_offs_r.cx);
        vy_nxt = vy_nxt - VW'(em_offs_r.cy);
      end
      default: begin
      end
    endcase
    vx_sat = (vx_nxt > SAT_HI) ? SAT_HI : ((vx_nxt < SAT_LO) ? SAT_LO : vx_nxt);
    vy_sat = (vy_nxt > SAT_HI) ? SAT_HI : ((vy_nxt < SAT_LO) ? SAT_LO : vy_nxt);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_v_r <= 1'b0;
      em_k_r <= '0;
    end else begin
      if (em_load_ok) em_v_r <= s7_v_r;
      if (em_load_ok && s7_v_r) begin
        em_k_r <= '0;
      end else if (em_v_r && out_free) begin
        em_k_r <= em_k_r + KW'(1);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (em_load_ok && s7_v_r) begin
      em_side_r <= s7_side_r;
      em_offs_r <= s7_offs_r;
    end
  end

  // output register
  logic [CW-1:0] out_vx_r, out_vy_r;
  logic [KW-1:0] out_num_r;
  logic out_last_r, out_degen_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= em_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (out_free && em_v_r) begin
      out_vx_r    <= vx_sat[CW-1:0];
      out_vy_r    <= vy_sat[CW-1:0];
      out_num_r   <= em_k_r;
      out_last_r  <= (em_k_r == VERTEX_LAST);
      out_degen_r <= em_side_r.degen;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_TW-2*CW-KW){1'b0}}, out_num_r, out_vy_r, out_vx_r};
  assign out_tuser  = out_degen_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

### design/tlte_checker.sv
`default_nettype none
`include "assert_macros.svh"
module tlte_checker import tlte_pkg::*; (
  input wire              clk,
  input wire              rst_n,
  input wire              out_tvalid,
  input wire              out_tready,
  input wire [OUT_TW-1:0] out_tdata,
  input wire              out_tuser,
  input wire              out_tlast
);

  logic [KW-1:0] num;
  assign num = out_tdata[2*CW +: KW];

  `TLTE_ASSERT_NXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `TLTE_ASSERT_IMP(a_last, out_tvalid, out_tlast == (num == VERTEX_LAST))
  `TLTE_ASSERT_IMP(a_count, out_tvalid && out_tready && !out_tlast ##1 out_tvalid, num == $past(num) + KW'(1))
  `TLTE_ASSERT_IMP(a_degen, out_tvalid && out_tready && !out_tlast ##1 out_tvalid, out_tuser == $past(out_tuser))

endmodule

bind thick_line_triangle_expander_core tlte_checker u_tlte_checker (.*);
`default_nettype wire
